// ===== rtl/u2g_pkg.sv =====
// Package for the UTF-8 to GSM 7-bit / UCS2-hex transcoder.
// Holds codes, the request record passed front to back, the GSM lookup table and helpers.
// No dependencies.
package u2g_pkg;

    localparam int BYTE_W   = 8;
    localparam int SEQ_LEN  = 4;                    // bytes per request and buffered UTF-8 bytes
    localparam int SEQ_IDX_W = $clog2(SEQ_LEN);
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);

    // input kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // charset modes
    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_GSM  = 2'd1;
    localparam logic [1:0] MODE_UCS2 = 2'd2;

    localparam logic [7:0] SEND_MARK  = 8'h1A;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_TWO  = 8'h32;

    // one request: up to four bytes toward the modem
    typedef struct packed {
        logic [SEQ_LEN-1:0][BYTE_W-1:0] bytes;
        logic [SEQ_IDX_W-1:0]           last_idx;
    } u2g_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } u2g_q_stat_t;

    typedef struct packed {
        logic       found;
        logic [6:0] code;
    } u2g_hit_t;

    localparam int GSM_MAP_SIZE = 42;

    localparam logic [6:0] GSM_CODE [GSM_MAP_SIZE] = '{
        7'h00, 7'h10, 7'h40, 7'h60, 7'h01, 7'h11, 7'h02, 7'h12, 7'h03, 7'h13,
        7'h04, 7'h14, 7'h24, 7'h05, 7'h15, 7'h06, 7'h16, 7'h07, 7'h17, 7'h08,
        7'h18, 7'h09, 7'h19, 7'h0B, 7'h5B, 7'h7B, 7'h0C, 7'h1C, 7'h5C, 7'h7C,
        7'h1D, 7'h5D, 7'h7D, 7'h0E, 7'h1E, 7'h5E, 7'h7E, 7'h0F, 7'h1F, 7'h5F,
        7'h7F, 7'h00
    };
    // last entry is a filler that never matches (length 0)
    localparam logic [2:0] GSM_LEN [GSM_MAP_SIZE] = '{
        3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd2, 3'd0
    };
    localparam logic [7:0] GSM_B0 [GSM_MAP_SIZE] = '{
        8'h40, 8'hCE, 8'hC2, 8'hC2, 8'hC2, 8'h5F, 8'h24, 8'hCE, 8'hC2, 8'hCE,
        8'hC3, 8'hCE, 8'hC2, 8'hC3, 8'hCE, 8'hC3, 8'hCE, 8'hC3, 8'hCE, 8'hC3,
        8'hCE, 8'hC3, 8'hCE, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3,
        8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC2,
        8'hC3, 8'h00
    };
    localparam logic [7:0] GSM_B1 [GSM_MAP_SIZE] = '{
        8'h00, 8'h94, 8'hA1, 8'hBF, 8'hA3, 8'h00, 8'h00, 8'hA6, 8'hA5, 8'h93,
        8'hA8, 8'h9B, 8'hA4, 8'hA9, 8'hA9, 8'hB9, 8'hA0, 8'hAC, 8'hA8, 8'hB2,
        8'hA3, 8'h87, 8'h98, 8'h98, 8'h84, 8'hA4, 8'hB8, 8'h86, 8'h96, 8'hB6,
        8'hA6, 8'h91, 8'hB1, 8'h85, 8'h9F, 8'h9C, 8'hBC, 8'hA5, 8'h89, 8'hA7,
        8'hA0, 8'h00
    };

    // first table entry matching the buffered sequence
    function automatic u2g_hit_t gsm_lookup(logic [2:0] len, logic [7:0] b0, logic [7:0] b1);
        u2g_hit_t hit;
        hit = '0;
        for (int i = 0; i < GSM_MAP_SIZE; i++) begin
            if (!hit.found && GSM_LEN[i] == len && GSM_B0[i] == b0 &&
                (GSM_LEN[i] != 3'd2 || GSM_B1[i] == b1))
            begin
                hit.found = 1'b1;
                hit.code  = GSM_CODE[i];
            end
        end
        return hit;
    endfunction

    function automatic logic gsm_candidate(logic [7:0] c);
        return c[7] || c <= 8'h24 || c[4:0] == 5'd0 || c[4:0] >= 5'h1B;
    endfunction

    // uppercase ASCII hex digit
    function automatic logic [7:0] hex_digit(logic [3:0] v);
        return (v <= 4'd9) ? ASCII_ZERO + {4'd0, v} : 8'h37 + {4'd0, v};
    endfunction

endpackage

// ===== rtl/u2g_if.sv =====
// Valid/ready stream interfaces for the transcoder's text and modem channels.
// Depends on nothing.
interface u2g_text_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface u2g_modem_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== rtl/u2g_front.sv =====
// Front end: accepts text items, tracks UTF-8 sequence state and builds byte requests.
// Depends on u2g_pkg and u2g_text_if.
module u2g_front
    import u2g_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    u2g_text_if.sink         text,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_wdata,
    input  u2g_q_stat_t      q_stat,
    output logic             push,
    output u2g_req_t         req
);

    logic [1:0]                     mode_reg;
    logic                           send_reg, send_next;
    logic [2:0]                     cnt_reg, cnt_next, cnt_inc;
    logic [SEQ_LEN-1:0][BYTE_W-1:0] buf_reg, buf_next, buf_w;
    logic [SEQ_LEN-1:0][BYTE_W-1:0] res;
    logic [2:0]                     nres;
    logic                           accept, complete;
    logic [7:0]                     c, b0, b1;
    u2g_hit_t                       hit;

    assign text.ready = !q_stat.full;
    assign accept     = text.valid && text.ready;
    assign c          = text.data_byte;

    always_comb
    begin
        cnt_inc = cnt_reg + 3'd1;
        buf_w   = buf_reg;
        buf_w[cnt_reg[SEQ_IDX_W-1:0]] = c;
        b0       = buf_w[0];
        b1       = buf_w[1];
        complete = !b0[7] || (cnt_inc == 3'd2 && b0[7:5] == 3'b110) ||
                   (cnt_inc == 3'd3 && b0[7:4] == 4'hE) || cnt_inc >= 3'd4;
        hit      = gsm_lookup(cnt_inc, b0, b1);

        res       = '0;
        nres      = 3'd0;
        cnt_next  = cnt_reg;
        buf_next  = buf_reg;
        send_next = send_reg;

        case (text.kind)
            KIND_START:
            begin
                cnt_next  = 3'd0;
                send_next = 1'b1;
            end
            KIND_DATA:
            begin
                if (send_reg)
                begin
                    case (mode_reg)
                        MODE_GSM:
                        begin
                            if (!gsm_candidate(c))
                            begin
                                res[0] = c;
                                nres   = 3'd1;
                            end
                            else
                            begin
                                buf_next = buf_w;
                                cnt_next = cnt_inc;
                                if (complete)
                                begin
                                    cnt_next = 3'd0;
                                    if (hit.found)
                                    begin
                                        res[0] = {1'b0, hit.code};
                                        nres   = 3'd1;
                                    end
                                    else
                                    begin
                                        // no match: echo the raw sequence
                                        res  = buf_w;
                                        nres = cnt_inc;
                                    end
                                end
                            end
                        end
                        MODE_UCS2:
                        begin
                            if (!c[7])
                            begin
                                res[0]   = ASCII_ZERO;
                                res[1]   = ASCII_ZERO;
                                res[2]   = hex_digit(c[7:4]);
                                res[3]   = hex_digit(c[3:0]);
                                nres     = 3'd4;
                                cnt_next = 3'd0;
                            end
                            else
                            begin
                                buf_next = buf_w;
                                cnt_next = 3'd0;
                                nres     = 3'd4;
                                res[3]   = hex_digit(c[3:0]);
                                if (cnt_inc == 3'd2 && b0[7:5] == 3'b110)
                                begin
                                    res[0] = ASCII_ZERO;
                                    res[1] = hex_digit(b0[5:2]);
                                    res[2] = hex_digit({b0[1:0], c[5:4]});
                                end
                                else if (cnt_inc == 3'd3 && b0[7:4] == 4'hE)
                                begin
                                    res[0] = hex_digit(b0[3:0]);
                                    res[1] = hex_digit(b1[5:2]);
                                    res[2] = hex_digit({b1[1:0], c[5:4]});
                                end
                                else if (cnt_inc >= 3'd4)
                                begin
                                    // four-byte or malformed sequence gives a space
                                    res[0] = ASCII_ZERO;
                                    res[1] = ASCII_ZERO;
                                    res[2] = ASCII_TWO;
                                    res[3] = ASCII_ZERO;
                                end
                                else
                                begin
                                    nres     = 3'd0;
                                    cnt_next = cnt_inc;
                                end
                            end
                        end
                        default:
                        begin
                            res[0] = c;
                            nres   = 3'd1;
                        end
                    endcase
                end
            end
            KIND_END:
            begin
                if (send_reg)
                begin
                    // pending bytes, then the send mark
                    res  = buf_reg;
                    res[cnt_reg[SEQ_IDX_W-1:0]] = SEND_MARK;
                    nres = cnt_inc;
                    cnt_next = 3'd0;
                end
            end
            default:
            begin
                nres = 3'd0;
            end
        endcase
    end

    assign push         = accept && nres != 3'd0;
    assign req.bytes    = res;
    assign req.last_idx = SEQ_IDX_W'(nres - 3'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PASS;
            send_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (accept)
            begin
                send_reg <= send_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    // buffer entries are read only below the fill count, so no reset is needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_reg <= buf_next;
        end
    end

endmodule

// ===== rtl/u2g_queue.sv =====
// Short request queue between front and back ends.
// Depends on u2g_pkg.
module u2g_queue
    import u2g_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  u2g_req_t    push_req,
    input  logic        pop,
    output u2g_req_t    head,
    output u2g_q_stat_t stat
);

    u2g_req_t           slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_PTR_W:0]   cnt_reg;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.full  = cnt_reg == (Q_PTR_W + 1)'(Q_DEPTH);
    assign stat.empty = cnt_reg == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// ===== rtl/u2g_back.sv =====
// Back end: one head request byte a cycle, when not stalled, to the modem register.
// Depends on u2g_pkg and u2g_modem_if.
module u2g_back
    import u2g_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  u2g_req_t    head,
    input  u2g_q_stat_t q_stat,
    output logic        pop,
    u2g_modem_if.source modem
);

    logic                 valid_reg;
    logic [7:0]           byte_reg;
    logic                 last_reg;
    logic [SEQ_IDX_W-1:0] idx_reg;
    logic                 load, take;

    assign load = !valid_reg || modem.ready;
    assign take = load && !q_stat.empty;
    assign pop  = take && idx_reg == head.last_idx;

    assign modem.valid    = valid_reg;
    assign modem.out_byte = byte_reg;
    assign modem.last     = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= !q_stat.empty;
            end
            if (take)
            begin
                idx_reg <= pop ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= head.bytes[idx_reg];
            last_reg <= pop;
        end
    end

endmodule

// ===== rtl/utf8_to_gsm_ucs2_encoder_top.sv =====
// Top level of the UTF-8 to GSM 7-bit / UCS2-hex transcoder.
// Depends on u2g_pkg, u2g_if, u2g_front, u2g_queue and u2g_back.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-----------------------------------------
//  text    | in  | valid/ready   | kind[1:0], data_byte[7:0]
//  modem   | out | valid/ready   | out_byte[7:0], last (final byte of item)
//  cfg     | in  | cfg_we        | cfg_wdata[1:0] = charset_mode
//
// The front end takes one text item per cycle while the two-entry request
// queue has room; it decides the whole byte list of an item in that cycle.
// The back end sends one byte per cycle while the modem is ready, so an item
// that makes n bytes (1 to 4) holds the modem port until all n are sent;
// sustained intake is then set by the byte-wide modem port.
// Items that make no bytes (start, partial sequences) take no queue entry.
// Reset is asynchronous, active low; no clearing pass is needed.
// A stalled modem port fills the queue and then drops text.ready.
module utf8_to_gsm_ucs2_encoder_top
    import u2g_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    u2g_text_if.sink    text,
    u2g_modem_if.source modem,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata
);

    logic        push;
    logic        pop;
    u2g_req_t    push_req;
    u2g_req_t    head;
    u2g_q_stat_t q_stat;

    // classify and decide byte lists
    u2g_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_stat    (q_stat),
        .push      (push),
        .req       (push_req)
    );

    // decouples front and back
    u2g_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    // byte serializer with output register
    u2g_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .modem  (modem)
    );

endmodule

// ===== rtl/u2g_checker.sv =====
// Port-level checks for the transcoder top level, attached by bind.
// Depends on utf8_to_gsm_ucs2_encoder_top.
module u2g_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       text_ready,
    input logic       modem_valid,
    input logic       modem_ready,
    input logic [7:0] modem_byte,
    input logic       modem_last
);

    // a pending output byte holds until taken
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        modem_valid && !modem_ready |=> modem_valid)
        else $error("modem valid dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        modem_valid && !modem_ready |=> $stable(modem_byte) && $stable(modem_last))
        else $error("modem payload changed while stalled");

    // an idle output register means the queue cannot be full
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !modem_valid |-> text_ready)
        else $error("text not ready while output idle");

    // bytes offered to the modem are always fully defined
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        modem_valid |-> !$isunknown({modem_byte, modem_last}))
        else $error("unknown modem byte or last");

endmodule

bind utf8_to_gsm_ucs2_encoder_top u2g_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .text_ready  (text.ready),
    .modem_valid (modem.valid),
    .modem_ready (modem.ready),
    .modem_byte  (modem.out_byte),
    .modem_last  (modem.last)
);

// ===== dv/utf8_to_gsm_ucs2_encoder_top_test.sv =====
// Self-checking testbench for utf8_to_gsm_ucs2_encoder_top: directed table, then random
// UTF-8 traffic in every charset mode, checked against a cycle-free transcoder model.
// Depends on u2g_pkg, u2g_if and the RTL of the transcoder.
module utf8_to_gsm_ucs2_encoder_top_test;
    import u2g_pkg::*;

    // selector values the package leaves unnamed
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    localparam int TAIL_CYCLES   = 8;      // front end + two-entry queue + back end, with margin
    localparam int PHASE_ITEMS   = 17;
    localparam int NUM_PHASES    = 6;
    localparam int PRESSURE_PH   = 4;
    localparam int BURST_CYCLES  = 64;

    // GSM 7-bit table: {code, first byte, second byte}; second byte 00 marks a 1-byte entry
    localparam int GSM_ENTRIES = 41;
    localparam logic [23:0] GSM_TABLE [GSM_ENTRIES] = '{
        24'h00_40_00, 24'h10_CE_94, 24'h40_C2_A1, 24'h60_C2_BF, 24'h01_C2_A3,
        24'h11_5F_00, 24'h02_24_00, 24'h12_CE_A6, 24'h03_C2_A5, 24'h13_CE_93,
        24'h04_C3_A8, 24'h14_CE_9B, 24'h24_C2_A4, 24'h05_C3_A9, 24'h15_CE_A9,
        24'h06_C3_B9, 24'h16_CE_A0, 24'h07_C3_AC, 24'h17_CE_A8, 24'h08_C3_B2,
        24'h18_CE_A3, 24'h09_C3_87, 24'h19_CE_98, 24'h0B_C3_98, 24'h5B_C3_84,
        24'h7B_C3_A4, 24'h0C_C3_B8, 24'h1C_C3_86, 24'h5C_C3_96, 24'h7C_C3_B6,
        24'h1D_C3_A6, 24'h5D_C3_91, 24'h7D_C3_B1, 24'h0E_C3_85, 24'h1E_C3_9F,
        24'h5E_C3_9C, 24'h7E_C3_BC, 24'h0F_C3_A5, 24'h1F_C3_89, 24'h5F_C2_A7,
        24'h7F_C3_A0
    };

    // per-phase charset mode and idling (percent of cycles)
    localparam logic [1:0] PHASE_MODE [NUM_PHASES] =
        '{MODE_GSM, MODE_UCS2, MODE_PASS, MODE_GSM, MODE_UCS2, MODE_SPARE};
    localparam int PHASE_SRC_IDLE   [NUM_PHASES] = '{0, 87, 0, 34, 0, 0};
    localparam int PHASE_SINK_STALL [NUM_PHASES] = '{0, 0, 87, 34, 0, 0};

    // one row of the directed table; a mode row only writes charset_mode
    typedef struct packed {
        logic        set_mode;
        logic [1:0]  mode;
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        typed;      // 1: expected bytes given below, 0: from the model
        logic [2:0]  n_out;
        logic [31:0] outs;       // first byte in [31:24]
    } stim_row_t;

    localparam int DIR_ROWS = 29;
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        // passthrough: data, end, unused kind idle until start; then data passes, end sends 1A
        '{1'b0, MODE_PASS, KIND_DATA,   8'h41, 1'b1, 3'd0, 32'h0},
        '{1'b0, MODE_PASS, KIND_END,    8'h00, 1'b1, 3'd0, 32'h0},
        '{1'b0, MODE_PASS, KIND_UNUSED, 8'hFF, 1'b1, 3'd0, 32'h0},
        '{1'b0, MODE_PASS, KIND_START,  8'h00, 1'b1, 3'd0, 32'h0},
        '{1'b0, MODE_PASS, KIND_DATA,   8'h00, 1'b1, 3'd1, 32'h00_000000},
        '{1'b0, MODE_PASS, KIND_DATA,   8'hFF, 1'b1, 3'd1, 32'hFF_000000},
        '{1'b0, MODE_PASS, KIND_END,    8'h00, 1'b1, 3'd1, 32'h1A_000000},
        // GSM: table hits, a plain copy, an unknown 3-byte sequence, end with a pending byte
        '{1'b1, MODE_GSM,  KIND_START,  8'h00, 1'b0, 3'd0, 32'h0},
        '{1'b0, MODE_PASS, KIND_START,  8'h00, 1'b1, 3'd0, 32'h0},
        '{1'b0, MODE_PASS, KIND_DATA,   8'h40, 1'b1, 3'd1, 32'h00_000000},
        '{1'b0, MODE_PASS, KIND_DATA,   8'hC3, 1'b1, 3'd0, 32'h0},
        '{1'b0, MODE_PASS, KIND_DATA,   8'hA9, 1'b1, 3'd1, 32'h05_000000},
        '{1'b0, MODE_PASS, KIND_DATA,   8'h41, 1'b1, 3'd1, 32'h41_000000},
        '{1'b0, MODE_PASS, KIND_DATA,   8'hE2, 1'b1, 3'd0, 32'h0},
        '{1'b0, MODE_PASS, KIND_DATA,   8'h82, 1'b1, 3'd0, 32'h0},
        '{1'b0, MODE_PASS, KIND_DATA,   8'hAC, 1'b0, 3'd0, 32'h0},
        '{1'b0, MODE_PASS, KIND_DATA,   8'hC3, 1'b1, 3'd0, 32'h0},
        '{1'b0, MODE_PASS, KIND_END,    8'h00, 1'b1, 3'd2, 32'hC3_1A_0000},
        // UCS2 after end (still sending): ASCII, 2-byte, 4-byte, 3-byte
        '{1'b1, MODE_UCS2, KIND_START,  8'h00, 1'b0, 3'd0, 32'h0},
        '{1'b0, MODE_PASS, KIND_DATA,   8'h7A, 1'b1, 3'd4, 32'h30_30_37_41},
        '{1'b0, MODE_PASS, KIND_DATA,   8'hC3, 1'b1, 3'd0, 32'h0},
        '{1'b0, MODE_PASS, KIND_DATA,   8'hA9, 1'b1, 3'd4, 32'h30_30_45_39},
        '{1'b0, MODE_PASS, KIND_DATA,   8'hF0, 1'b1, 3'd0, 32'h0},
        '{1'b0, MODE_PASS, KIND_DATA,   8'h9F, 1'b1, 3'd0, 32'h0},
        '{1'b0, MODE_PASS, KIND_DATA,   8'h98, 1'b1, 3'd0, 32'h0},
        '{1'b0, MODE_PASS, KIND_DATA,   8'h80, 1'b1, 3'd4, 32'h30_30_32_30},
        '{1'b0, MODE_PASS, KIND_DATA,   8'hE2, 1'b0, 3'd0, 32'h0},
        '{1'b0, MODE_PASS, KIND_DATA,   8'h82, 1'b0, 3'd0, 32'h0},
        '{1'b0, MODE_PASS, KIND_DATA,   8'hAC, 1'b0, 3'd0, 32'h0}
    };

    typedef struct packed {
        logic [7:0] octet;
        logic       last;
    } modem_beat_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_wdata;

    u2g_text_if  text_bus ();
    u2g_modem_if modem_bus ();

    utf8_to_gsm_ucs2_encoder_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text_bus),
        .modem     (modem_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // bytes still owed on the modem port, oldest first
    modem_beat_t bytes_due [$];
    int          fail_count  = 0;
    int          src_idle    = 0;
    int          sink_stall  = 0;
    int          stall_burst = 0;   // set once; the modem side counts the stretch itself
    int          phase_items;

    // transcoder state as the modem sees it
    logic [7:0] seq_buf [4] = '{default: 8'h00};
    logic [2:0] seq_cnt     = 3'd0;
    logic       sending     = 1'b0;
    logic [1:0] cur_mode    = MODE_PASS;
    logic [7:0] pred_out [4];
    int         pred_n;

    // ------------------------------------------------------------------
    // transcoder model
    // ------------------------------------------------------------------
    function automatic void put_byte(input logic [7:0] b);
        pred_out[pred_n] = b;
        pred_n++;
    endfunction

    function automatic logic [7:0] ascii_hex(input logic [3:0] v);
        return (v <= 4'd9) ? 8'h30 + 8'(v) : 8'h37 + 8'(v);
    endfunction

    function automatic logic gsm_wants(input logic [7:0] c);
        return c >= 8'h80 || c <= 8'h24 || c[4:0] == 5'd0 || c[4:0] >= 5'h1B;
    endfunction

    // table lookup on the buffered sequence; only 1- and 2-byte entries exist
    function automatic logic gsm_code_of(output logic [7:0] code);
        logic [2:0] len;
        code = 8'h00;
        for (int i = 0; i < GSM_ENTRIES; i++)
        begin
            len = (GSM_TABLE[i][7:0] == 8'h00) ? 3'd1 : 3'd2;
            if (seq_cnt == len && seq_buf[0] == GSM_TABLE[i][15:8] &&
                (len != 3'd2 || seq_buf[1] == GSM_TABLE[i][7:0]))
            begin
                code = GSM_TABLE[i][23:16];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void echo_pending();
        for (int i = 0; i < seq_cnt && i < 4; i++)
            put_byte(seq_buf[i]);
        seq_cnt = 3'd0;
    endfunction

    function automatic void gsm_step(input logic [7:0] c);
        logic [7:0] lead;
        logic [7:0] code;
        if (!gsm_wants(c))
        begin
            put_byte(c);        // pending partial sequence stays put
            return;
        end
        seq_buf[seq_cnt[1:0]] = c;
        seq_cnt = seq_cnt + 3'd1;
        lead = seq_buf[0];
        if (lead < 8'h80 || (seq_cnt == 3'd2 && lead[7:5] == 3'b110) ||
            (seq_cnt == 3'd3 && lead[7:4] == 4'b1110) || seq_cnt >= 3'd4)
        begin
            if (gsm_code_of(code))
            begin
                seq_cnt = 3'd0;
                put_byte(code);
            end
            else
                echo_pending();
        end
    endfunction

    function automatic void ucs2_step(input logic [7:0] c);
        logic [7:0] b0;
        logic [7:0] b1;
        if (c < 8'h80)
        begin
            // ASCII drops any half-built sequence
            put_byte(8'h30);
            put_byte(8'h30);
            put_byte(ascii_hex(c[7:4]));
            put_byte(ascii_hex(c[3:0]));
            seq_cnt = 3'd0;
            return;
        end
        seq_buf[seq_cnt[1:0]] = c;
        seq_cnt = seq_cnt + 3'd1;
        b0 = seq_buf[0];
        b1 = seq_buf[1];
        if (seq_cnt == 3'd2 && b0[7:5] == 3'b110)
        begin
            put_byte(8'h30);
            put_byte(ascii_hex(b0[5:2]));
            put_byte(ascii_hex({b0[1:0], c[5:4]}));
            put_byte(ascii_hex(c[3:0]));
            seq_cnt = 3'd0;
        end
        else if (seq_cnt == 3'd3 && b0[7:4] == 4'b1110)
        begin
            put_byte(ascii_hex(b0[3:0]));
            put_byte(ascii_hex(b1[5:2]));
            put_byte(ascii_hex({b1[1:0], c[5:4]}));
            put_byte(ascii_hex(c[3:0]));
            seq_cnt = 3'd0;
        end
        else if (seq_cnt >= 3'd4)
        begin
            // 4-byte or broken sequence becomes a space
            put_byte(8'h30);
            put_byte(8'h30);
            put_byte(8'h32);
            put_byte(8'h30);
            seq_cnt = 3'd0;
        end
    endfunction

    // fills pred_out / pred_n with the bytes one request causes
    function automatic void transcode_item(input logic [1:0] k, input logic [7:0] c);
        pred_n = 0;
        if (k == KIND_START)
        begin
            seq_buf = '{default: 8'h00};
            seq_cnt = 3'd0;
            sending = 1'b1;
        end
        else if (k != KIND_UNUSED && sending)
        begin
            if (k == KIND_END)
            begin
                echo_pending();
                put_byte(SEND_MARK);
            end
            else if (cur_mode == MODE_GSM)
                gsm_step(c);
            else if (cur_mode == MODE_UCS2)
                ucs2_step(c);
            else
                put_byte(c);
        end
    endfunction

    function automatic void book_byte(input logic [7:0] b, input logic lst);
        modem_beat_t beat;
        beat.octet = b;
        beat.last  = lst;
        bytes_due.push_back(beat);
    endfunction

    // ------------------------------------------------------------------
    // text side
    // ------------------------------------------------------------------
    // Holds valid through back-to-back requests; drops it only for idle cycles.
    task automatic send_text(input logic [1:0] k, input logic [7:0] d);
        while (src_idle != 0 && $urandom_range(99) < src_idle)
        begin
            text_bus.valid <= 1'b0;
            @(posedge clk);
        end
        text_bus.valid     <= 1'b1;
        text_bus.kind      <= k;
        text_bus.data_byte <= d;
        @(posedge clk);
        while (!text_bus.ready)
            @(posedge clk);
    endtask

    task automatic offer(input logic [1:0] k, input logic [7:0] d);
        send_text(k, d);
        transcode_item(k, d);
        for (int i = 0; i < pred_n; i++)
            book_byte(pred_out[i], i == pred_n - 1);
        if (k != KIND_UNUSED)
            phase_items++;
    endtask

    // One random word: mostly well-formed UTF-8 with random content, some noise.
    task automatic send_word();
        int         pick;
        int         idx;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            idx = $urandom_range(GSM_ENTRIES - 1);
            offer(KIND_DATA, GSM_TABLE[idx][15:8]);
            if (GSM_TABLE[idx][7:0] != 8'h00)
                offer(KIND_DATA, GSM_TABLE[idx][7:0]);
        end
        else if (pick < 40)
        begin
            b = 8'($urandom_range(8'h7F));
            offer(KIND_DATA, b);
        end
        else if (pick < 55)
        begin
            b = 8'($urandom_range(8'hDF, 8'hC0));
            offer(KIND_DATA, b);
            b = 8'($urandom_range(8'hBF, 8'h80));
            offer(KIND_DATA, b);
        end
        else if (pick < 67)
        begin
            b = 8'($urandom_range(8'hEF, 8'hE0));
            offer(KIND_DATA, b);
            repeat (2)
            begin
                b = 8'($urandom_range(8'hBF, 8'h80));
                offer(KIND_DATA, b);
            end
        end
        else if (pick < 75)
        begin
            b = 8'($urandom_range(8'hF7, 8'hF0));
            offer(KIND_DATA, b);
            repeat (3)
            begin
                b = 8'($urandom_range(8'hBF, 8'h80));
                offer(KIND_DATA, b);
            end
        end
        else if (pick < 88)
        begin
            b = 8'($urandom_range(8'hFF));
            offer(KIND_DATA, b);
        end
        else if (pick < 93)
        begin
            // stray lead byte, left open
            b = 8'($urandom_range(8'hFF, 8'hC0));
            offer(KIND_DATA, b);
        end
        else if (pick < 96)
        begin
            b = 8'($urandom_range(8'hFF));
            offer(KIND_END, b);
        end
        else if (pick < 98)
        begin
            b = 8'($urandom_range(8'hFF));
            offer(KIND_START, b);
        end
        else
        begin
            b = 8'($urandom_range(8'hFF));
            offer(KIND_UNUSED, b);
        end
    endtask

    // Sender pause: every owed byte delivered, then a tail wait for requests that
    // cause no byte but may still be in flight.
    task automatic wait_idle();
        text_bus.valid <= 1'b0;
        while (bytes_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_mode = m;
    endtask

    // ------------------------------------------------------------------
    // clock, limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // far beyond the slowest legal run (~130 requests x 4 bytes under heavy stalls)
    initial
    begin
        #400000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // modem side: random stalls, one long hold-off, in-order byte check
    // ------------------------------------------------------------------
    initial
    begin : modem_side
        int          hold;
        logic        burst_taken;
        modem_beat_t want;
        hold        = 0;
        burst_taken = 1'b0;
        modem_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (modem_bus.valid && modem_bus.ready)
            begin
                if (bytes_due.size() == 0)
                begin
                    $display("%0t: modem byte expected none actual %02h last %0b", $time,
                             modem_bus.out_byte, modem_bus.last);
                    fail_count++;
                end
                else
                begin
                    want = bytes_due.pop_front();
                    if (modem_bus.out_byte !== want.octet)
                    begin
                        $display("%0t: out_byte expected %02h actual %02h", $time,
                                 want.octet, modem_bus.out_byte);
                        fail_count++;
                    end
                    if (modem_bus.last !== want.last)
                    begin
                        $display("%0t: last expected %0b actual %0b", $time,
                                 want.last, modem_bus.last);
                        fail_count++;
                    end
                end
            end
            // long hold-off: the queue fills and text.ready must drop
            if (!burst_taken && stall_burst != 0)
            begin
                hold        = stall_burst;
                burst_taken = 1'b1;
            end
            if (hold > 0)
            begin
                hold--;
                modem_bus.ready <= 1'b0;
            end
            else
                modem_bus.ready <= ($urandom_range(99) >= sink_stall);
        end
    end

    // ------------------------------------------------------------------
    // stimulus: reset, directed table, random phases, drain, verdict
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        stim_row_t row;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= MODE_PASS;
        text_bus.valid     <= 1'b0;
        text_bus.kind      <= KIND_START;
        text_bus.data_byte <= 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: typed rows give their bytes, the rest come from the model
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row = DIRECTED[r];
            if (row.set_mode)
            begin
                wait_idle();
                write_mode(row.mode);
            end
            else
            begin
                send_text(row.kind, row.data);
                transcode_item(row.kind, row.data);
                if (row.typed)
                begin
                    for (int i = 0; i < row.n_out; i++)
                        book_byte(row.outs[31 - 8 * i -: 8], i == row.n_out - 1);
                end
                else
                begin
                    for (int i = 0; i < pred_n; i++)
                        book_byte(pred_out[i], i == pred_n - 1);
                end
            end
        end

        // random phases, each from a quiet block with a fresh mode
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            write_mode(PHASE_MODE[p]);
            src_idle   = PHASE_SRC_IDLE[p];
            sink_stall = PHASE_SINK_STALL[p];
            if (p == PRESSURE_PH)
                stall_burst <= BURST_CYCLES;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                send_word();
        end

        wait_idle();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
